// ===== rtl/seven_segment_four_digit_driver_defines.svh =====
// Assertion macros for the seven-segment driver.
// Both assume a clock named clk and an active-low reset named rst_n in scope.
`ifndef SEVEN_SEGMENT_FOUR_DIGIT_DRIVER_DEFINES_SVH
`define SEVEN_SEGMENT_FOUR_DIGIT_DRIVER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define SSD_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("seven segment driver check failed");

`define SSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error("seven segment driver sequence check failed");

`else

`define SSD_ASSERT(label, prop)

`define SSD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/ssd_pkg.sv =====
`default_nettype none

package ssd_pkg;

    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_DECIMAL   = 3'd1,
        CMD_HEX_BLANK = 3'd2,
        CMD_HEX_ZERO  = 3'd3,
        CMD_CHAR      = 3'd4,
        CMD_BITMAP    = 3'd5,
        CMD_DOT       = 3'd6,
        CMD_CLEAR     = 3'd7
    } ssd_cmd_t;

    typedef logic [3:0][7:0] seg_store_t;
    typedef logic [3:0][6:0] glyph_row_t;

    typedef struct packed {
        ssd_cmd_t    command;
        logic [15:0] value;
        logic [4:0]  dot_mode;
        logic [1:0]  position;
        logic [7:0]  char_code;
        logic [7:0]  bitmap;
        logic        dot_show;
    } ssd_item_t;

    typedef struct packed {
        logic        frame_valid;
        logic [15:0] frame;
        logic [1:0]  scanned_digit;
        logic        dot_lit;
    } ssd_result_t;

    localparam logic [4:0] DOT_HOLD = 5'd16;
    localparam logic [4:0] DOT_ON   = 5'd17;

    localparam logic [7:0] SEG_DARK = 8'hFF;

    localparam logic [7:0] CHAR_SPACE      = 8'h20;
    localparam logic [7:0] CHAR_MINUS      = 8'h2D;
    localparam logic [7:0] CHAR_ZERO       = 8'h30;
    localparam logic [7:0] CHAR_NINE       = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;
    localparam logic [7:0] CASE_BIT        = 8'h20;

    localparam logic [6:0] GLYPH_MINUS      = 7'h40;
    localparam logic [6:0] GLYPH_UNDERSCORE = 7'h08;
    localparam logic [6:0] GLYPH_BLANK      = 7'h00;

    localparam logic [7:0] DIGIT_GLYPH [10] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
    };

    localparam logic [7:0] SELECT_BYTE [4] = '{8'hF1, 8'hF2, 8'hF4, 8'hF8};

    localparam logic [6:0] LETTER_GLYPH [26] = '{
        7'd95, 7'd124, 7'd88, 7'd94, 7'd121, 7'd113, 7'd61, 7'd116, 7'd17,
        7'd13, 7'd117, 7'd56, 7'd85, 7'd84, 7'd92, 7'd115, 7'd103, 7'd80,
        7'd45, 7'd120, 7'd28, 7'd42, 7'd106, 7'd20, 7'd110, 7'd27
    };

    // active-high segments a-g for an ASCII code
    function automatic logic [6:0] glyph_of(input logic [7:0] c);
        logic [7:0] lc;
        logic [7:0] off;
        logic [6:0] g;
        lc = c;
        off = 8'd0;
        g = GLYPH_BLANK;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            lc = c | CASE_BIT;
        end
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            g = ~DIGIT_GLYPH[c[3:0]][6:0];
        end
        else if (lc >= CHAR_LOWER_A && lc <= CHAR_LOWER_Z)
        begin
            off = lc - CHAR_LOWER_A;
            g = LETTER_GLYPH[off[4:0]];
        end
        else if (c == CHAR_MINUS)
        begin
            g = GLYPH_MINUS;
        end
        else if (c == CHAR_UNDERSCORE)
        begin
            g = GLYPH_UNDERSCORE;
        end
        return g;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] c;
        if (n < 4'd10)
        begin
            c = 8'(CHAR_ZERO + {4'd0, n});
        end
        else
        begin
            c = 8'(CHAR_LOWER_A + {4'd0, n} - 8'd10);
        end
        return c;
    endfunction

    // dot of a freshly written digit, active high
    function automatic logic written_dot(input logic [4:0] mode, input logic old_bit);
        logic d;
        if (mode == DOT_HOLD)
        begin
            d = ~old_bit;
        end
        else
        begin
            d = (mode == DOT_ON);
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ssd_digits.sv =====
`default_nettype none

module ssd_digits (
    input  logic [15:0]         value,
    input  logic                decimal,
    input  logic                zero_pad,
    output ssd_pkg::glyph_row_t glyphs
);

    logic        neg;
    logic        out_of_range;
    logic [15:0] mag16;
    logic [13:0] mag;
    logic [27:0] p1;
    logic [27:0] p2;
    logic [27:0] p3;
    logic [9:0]  q1;
    logic [6:0]  q2;
    logic [3:0]  q3;
    logic [3:0]  dd [4];
    logic [3:0]  dec_blank;
    logic [7:0]  chars [4];

    assign neg          = value[15];
    assign out_of_range = neg ? (value < 16'hFC19) : (value > 16'd9999);
    assign mag16        = neg ? (16'd0 - value) : value;
    assign mag          = mag16[13:0];

    // reciprocal multiplies, exact for magnitudes up to 9999
    assign p1 = 28'(mag) * 28'd6554;
    assign p2 = 28'(mag) * 28'd5243;
    assign p3 = 28'(mag) * 28'd8389;
    assign q1 = p1[25:16];
    assign q2 = p2[25:19];
    assign q3 = p3[26:23];

    assign dd[0] = 4'(mag - 14'({q1, 3'b000}) - 14'({q1, 1'b0}));
    assign dd[1] = 4'(q1 - 10'({q2, 3'b000}) - 10'({q2, 1'b0}));
    assign dd[2] = 4'(q2 - 7'({q3, 3'b000}) - 7'({q3, 1'b0}));
    assign dd[3] = q3;

    assign dec_blank = {q3 == 4'd0, q2 == 7'd0, q1 == 10'd0, 1'b0};

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (decimal)
            begin
                if (out_of_range || (neg && i == 3))
                begin
                    chars[i] = ssd_pkg::CHAR_MINUS;
                end
                else if (dec_blank[i])
                begin
                    chars[i] = 8'd0;
                end
                else
                begin
                    chars[i] = 8'(ssd_pkg::CHAR_ZERO + {4'd0, dd[i]});
                end
            end
            else if (i > 0 && (value >> (4 * i)) == 16'd0)
            begin
                chars[i] = zero_pad ? ssd_pkg::CHAR_ZERO : ssd_pkg::CHAR_SPACE;
            end
            else
            begin
                chars[i] = ssd_pkg::hex_char(value[4 * i +: 4]);
            end
            glyphs[i] = ssd_pkg::glyph_of(chars[i]);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ssd_update.sv =====
`default_nettype none

module ssd_update (
    input  ssd_pkg::ssd_item_t   item,
    input  ssd_pkg::seg_store_t  store,
    input  logic [1:0]           scan,
    output ssd_pkg::seg_store_t  store_next,
    output logic [1:0]           scan_next,
    output ssd_pkg::ssd_result_t result
);

    logic [1:0]          idx;
    logic                mask_on;
    ssd_pkg::glyph_row_t glyphs;

    assign idx     = ~item.position;
    assign mask_on = !item.dot_mode[4] && (item.dot_mode[3:0] != 4'd0);

    ssd_digits u_digits (
        .value    (item.value),
        .decimal  (item.command == ssd_pkg::CMD_DECIMAL),
        .zero_pad (item.command == ssd_pkg::CMD_HEX_ZERO),
        .glyphs   (glyphs)
    );

    always_comb
    begin
        store_next           = store;
        scan_next            = scan;
        result.frame_valid   = 1'b0;
        result.frame         = 16'd0;
        result.scanned_digit = 2'd0;
        case (item.command)
            ssd_pkg::CMD_TICK:
            begin
                result.frame_valid   = 1'b1;
                result.frame         = {store[scan], ssd_pkg::SELECT_BYTE[scan]};
                result.scanned_digit = scan;
                scan_next            = scan + 2'd1;
            end
            ssd_pkg::CMD_DECIMAL, ssd_pkg::CMD_HEX_BLANK, ssd_pkg::CMD_HEX_ZERO:
            begin
                // position p lives at store index 3 - p
                for (int p = 0; p < 4; p++)
                begin
                    store_next[3 - p] = ~{ssd_pkg::written_dot(item.dot_mode,
                                                               store[3 - p][7]),
                                          glyphs[p]};
                    if (mask_on)
                    begin
                        store_next[3 - p][7] = ~item.dot_mode[p];
                    end
                end
            end
            ssd_pkg::CMD_CHAR:
            begin
                store_next[idx] = ~{ssd_pkg::written_dot(item.dot_mode, store[idx][7]),
                                    ssd_pkg::glyph_of(item.char_code)};
            end
            ssd_pkg::CMD_BITMAP:
            begin
                store_next[idx] = ~item.bitmap;
            end
            ssd_pkg::CMD_DOT:
            begin
                store_next[idx][7] = ~item.dot_show;
            end
            ssd_pkg::CMD_CLEAR:
            begin
                store_next = {4{ssd_pkg::SEG_DARK}};
            end
            default:
            begin
                store_next = store;
            end
        endcase
        result.dot_lit = ~store_next[idx][7];
    end

endmodule

`default_nettype wire

// ===== rtl/seven_segment_four_digit_driver.sv =====
// Four-digit multiplexed seven-segment driver.
// done pulses once the start transfer has passed the input register and the result register.
// One command per cycle; busy stays low, every command yields one result.
// Results cannot be stalled: each is valid for exactly the cycle that done is high.
// Reset: segment store goes dark (0xFF per digit), scan index returns to 0, no result pending.
`default_nettype none

`include "seven_segment_four_digit_driver_defines.svh"

module seven_segment_four_digit_driver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  command,
    input  logic [15:0] value,
    input  logic [4:0]  dot_mode,
    input  logic [1:0]  position,
    input  logic [7:0]  char_code,
    input  logic [7:0]  bitmap,
    input  logic        dot_show,
    output logic        done,
    output logic        frame_valid,
    output logic [15:0] frame,
    output logic [1:0]  scanned_digit,
    output logic        dot_lit
);

    logic                 accept;
    logic                 valid_reg;
    ssd_pkg::ssd_item_t   item_reg;
    ssd_pkg::ssd_item_t   item_next;
    ssd_pkg::seg_store_t  store_reg;
    ssd_pkg::seg_store_t  store_next;
    logic [1:0]           scan_reg;
    logic [1:0]           scan_next;
    ssd_pkg::ssd_result_t result;
    logic                 done_reg;
    logic                 frame_valid_reg;
    logic [15:0]          frame_reg;
    logic [1:0]           scanned_digit_reg;
    logic                 dot_lit_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        item_next.command   = ssd_pkg::ssd_cmd_t'(command);
        item_next.value     = value;
        item_next.dot_mode  = dot_mode;
        item_next.position  = position;
        item_next.char_code = char_code;
        item_next.bitmap    = bitmap;
        item_next.dot_show  = dot_show;
    end

    ssd_update u_update (
        .item       (item_reg),
        .store      (store_reg),
        .scan       (scan_reg),
        .store_next (store_next),
        .scan_next  (scan_next),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= 1'b0;
            store_reg       <= {4{ssd_pkg::SEG_DARK}};
            scan_reg        <= 2'd0;
            done_reg        <= 1'b0;
            frame_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg       <= accept;
            done_reg        <= valid_reg;
            frame_valid_reg <= valid_reg && result.frame_valid;
            if (valid_reg)
            begin
                store_reg <= store_next;
                scan_reg  <= scan_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
        if (valid_reg)
        begin
            frame_reg         <= result.frame;
            scanned_digit_reg <= result.scanned_digit;
            dot_lit_reg       <= result.dot_lit;
        end
    end

    assign done          = done_reg;
    assign frame_valid   = frame_valid_reg;
    assign frame         = frame_reg;
    assign scanned_digit = scanned_digit_reg;
    assign dot_lit       = dot_lit_reg;

    `SSD_ASSERT_NEXT(a_transfer_gives_done, start && !busy, ##1 done)
    `SSD_ASSERT_NEXT(a_no_transfer_no_done, !(start && !busy), ##1 !done)
    `SSD_ASSERT(a_frame_only_with_done, frame_valid |-> done)
    `SSD_ASSERT(a_select_matches_digit,
                frame_valid |-> frame[7:0] == ssd_pkg::SELECT_BYTE[scanned_digit])
    `SSD_ASSERT(a_scan_advanced, frame_valid |-> scan_reg == scanned_digit + 2'd1)

endmodule

`default_nettype wire
